// File: hw/rtl/lcrc_pkg.sv
// ----------------------------------------------------------------------------
// Line color run classifier package
// Shared widths, character codes, color codes and beat types.
// ----------------------------------------------------------------------------
package lcrc_pkg;

  localparam int unsigned ColBits   = 16;
  localparam int unsigned CharBits  = 8;
  localparam int unsigned TabBits   = 5;
  localparam int unsigned ColorBits = 3;

  localparam logic [TabBits-1:0] TabColumnsReset = 5'd4;

  localparam logic [ColorBits-1:0] ColorDefault = 3'd0;
  localparam logic [ColorBits-1:0] ColorString  = 3'd1;
  localparam logic [ColorBits-1:0] ColorComment = 3'd2;
  localparam logic [ColorBits-1:0] ColorNumber  = 3'd3;
  localparam logic [ColorBits-1:0] ColorBracket = 3'd4;
  localparam logic [ColorBits-1:0] ColorType    = 3'd5;

  localparam logic [CharBits-1:0] ChTab     = 8'h09;
  localparam logic [CharBits-1:0] ChSpace   = 8'h20;
  localparam logic [CharBits-1:0] ChDquote  = 8'h22;
  localparam logic [CharBits-1:0] ChSquote  = 8'h27;
  localparam logic [CharBits-1:0] ChSlash   = 8'h2F;
  localparam logic [CharBits-1:0] ChLparen  = 8'h28;
  localparam logic [CharBits-1:0] ChRparen  = 8'h29;
  localparam logic [CharBits-1:0] ChLess    = 8'h3C;
  localparam logic [CharBits-1:0] ChGreater = 8'h3E;
  localparam logic [CharBits-1:0] ChLbrack  = 8'h5B;
  localparam logic [CharBits-1:0] ChRbrack  = 8'h5D;
  localparam logic [CharBits-1:0] ChLbrace  = 8'h7B;
  localparam logic [CharBits-1:0] ChRbrace  = 8'h7D;
  localparam logic [CharBits-1:0] ChDigit0  = 8'h30;
  localparam logic [CharBits-1:0] ChDigit9  = 8'h39;
  localparam logic [CharBits-1:0] ChUpperA  = 8'h41;
  localparam logic [CharBits-1:0] ChUpperZ  = 8'h5A;
  localparam logic [CharBits-1:0] ChLowerA  = 8'h61;
  localparam logic [CharBits-1:0] ChLowerZ  = 8'h7A;

  localparam int unsigned TokDepth   = 4;
  localparam int unsigned TokPtrBits = $clog2(TokDepth);
  localparam int unsigned TokCntBits = $clog2(TokDepth + 1);
  localparam int unsigned ResDepth   = 4;
  localparam int unsigned ResPtrBits = $clog2(ResDepth);
  localparam int unsigned ResCntBits = $clog2(ResDepth + 1);

  typedef struct packed {
    logic [CharBits-1:0] character;
    logic                end_of_line;
    logic                no_character;
  } in_t;

  typedef struct packed {
    logic                 run_present;
    logic [ColBits-1:0]   run_start;
    logic [ColBits-1:0]   run_length;
    logic [ColorBits-1:0] run_color;
    logic [ColBits-1:0]   indent_width;
    logic                 line_done;
  } out_t;

  typedef struct packed {
    logic                 vis_a;
    logic [ColBits-1:0]   pos_a;
    logic [ColorBits-1:0] color_a;
    logic                 vis_b;
    logic [ColBits-1:0]   pos_b;
    logic [ColorBits-1:0] color_b;
    logic                 eol;
    logic [ColBits-1:0]   indent;
  } tok_t;

endpackage

// File: hw/rtl/lcrc_front.sv
// ----------------------------------------------------------------------------
// Line color run classifier front end
// Accepts characters, holds one as lookahead and classifies body characters.
// ----------------------------------------------------------------------------
module lcrc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [lcrc_pkg::TabBits-1:0]  cfg_data_i,
  input  logic                          push_i,
  input  lcrc_pkg::in_t                 in_i,
  input  logic                          tok_full_i,
  output logic                          tok_push_o,
  output lcrc_pkg::tok_t                tok_o
);

  typedef struct packed {
    logic                         in_indent;
    logic [lcrc_pkg::ColBits-1:0] indent;
    logic [lcrc_pkg::ColBits-1:0] pos;
    logic                         str;
    logic                         cmt;
  } lstate_t;

  typedef struct packed {
    lstate_t                        st;
    logic                           vis;
    logic [lcrc_pkg::ColBits-1:0]   pos;
    logic [lcrc_pkg::ColorBits-1:0] color;
  } cls_t;

  localparam lstate_t LineReset = '{in_indent: 1'b1, default: '0};

  function automatic logic [lcrc_pkg::ColBits-1:0] sat_add(
    logic [lcrc_pkg::ColBits-1:0] a, logic [lcrc_pkg::ColBits-1:0] b);
    logic [lcrc_pkg::ColBits:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[lcrc_pkg::ColBits] ? '1 : sum[lcrc_pkg::ColBits-1:0];
  endfunction

  function automatic cls_t classify(lstate_t s, logic [lcrc_pkg::CharBits-1:0] c,
                                    logic has_next, logic [lcrc_pkg::CharBits-1:0] nx,
                                    logic [lcrc_pkg::TabBits-1:0] tab);
    cls_t                         r;
    logic                         blank;
    logic                         is_br;
    logic [lcrc_pkg::ColBits-1:0] step;
    r       = '{st: s, vis: 1'b0, pos: s.pos, color: lcrc_pkg::ColorDefault};
    blank   = (c == lcrc_pkg::ChSpace) || (c == lcrc_pkg::ChTab);
    is_br   = (c == lcrc_pkg::ChLparen) || (c == lcrc_pkg::ChRparen) ||
              (c == lcrc_pkg::ChLbrace) || (c == lcrc_pkg::ChRbrace) ||
              (c == lcrc_pkg::ChLbrack) || (c == lcrc_pkg::ChRbrack) ||
              (c == lcrc_pkg::ChLess)   || (c == lcrc_pkg::ChGreater);
    step    = (c == lcrc_pkg::ChTab) ? lcrc_pkg::ColBits'(tab) : lcrc_pkg::ColBits'(1);
    if (s.in_indent && blank) begin
      r.st.indent = sat_add(s.indent, step);
    end else begin
      r.st.in_indent = 1'b0;
      if (!s.str && has_next && (c == lcrc_pkg::ChSlash) && (nx == lcrc_pkg::ChSlash)) begin
        r.st.cmt = 1'b1;
      end
      if (!r.st.cmt && ((c == lcrc_pkg::ChDquote) || (c == lcrc_pkg::ChSquote))) begin
        r.st.str = !s.str;
      end
      r.st.pos = sat_add(s.pos, lcrc_pkg::ColBits'(1));
      r.vis    = !blank;
      if (r.st.cmt) begin
        r.color = lcrc_pkg::ColorComment;
      end else if (r.st.str) begin
        r.color = lcrc_pkg::ColorString;
      end else if ((c >= lcrc_pkg::ChDigit0) && (c <= lcrc_pkg::ChDigit9)) begin
        r.color = lcrc_pkg::ColorNumber;
      end else if (is_br) begin
        r.color = lcrc_pkg::ColorBracket;
      end else if ((c >= lcrc_pkg::ChUpperA) && (c <= lcrc_pkg::ChUpperZ) && has_next &&
                   (nx >= lcrc_pkg::ChLowerA) && (nx <= lcrc_pkg::ChLowerZ)) begin
        r.color = lcrc_pkg::ColorType;
      end
    end
    return r;
  endfunction

  lstate_t                         line_q, line_d;
  logic [lcrc_pkg::CharBits-1:0]   held_q, held_d;
  logic                            held_valid_q, held_valid_d;
  logic [lcrc_pkg::TabBits-1:0]    tab_q, tab_d;
  logic                            accept;
  logic                            active;
  logic                            use_b;
  cls_t                            ra, rb;
  lstate_t                         s1;

  assign accept = push_i && !tok_full_i;
  assign active = !in_i.no_character || in_i.end_of_line;
  assign use_b  = !in_i.no_character && in_i.end_of_line;

  always_comb begin
    ra = classify(line_q, held_q, !in_i.no_character, in_i.character, tab_q);
    s1 = held_valid_q ? ra.st : line_q;
    rb = classify(s1, in_i.character, 1'b0, '0, tab_q);

    tok_o.vis_a   = held_valid_q && active && ra.vis;
    tok_o.pos_a   = ra.pos;
    tok_o.color_a = ra.color;
    tok_o.vis_b   = use_b && rb.vis;
    tok_o.pos_b   = rb.pos;
    tok_o.color_b = rb.color;
    tok_o.eol     = in_i.end_of_line;
    tok_o.indent  = use_b ? rb.st.indent : s1.indent;

    tok_push_o = accept && active && (tok_o.vis_a || tok_o.vis_b || tok_o.eol);

    line_d       = line_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    if (accept && active) begin
      if (in_i.end_of_line) begin
        line_d       = LineReset;
        held_d       = '0;
        held_valid_d = 1'b0;
      end else begin
        line_d       = s1;
        held_d       = in_i.character;
        held_valid_d = 1'b1;
      end
    end

    tab_d = cfg_valid_i ? cfg_data_i : tab_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q       <= LineReset;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      tab_q        <= lcrc_pkg::TabColumnsReset;
    end else begin
      line_q       <= line_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      tab_q        <= tab_d;
    end
  end

endmodule

// File: hw/rtl/lcrc_tok_fifo.sv
// ----------------------------------------------------------------------------
// Line color run classifier token queue
// Short queue of classified beats between the front end and the run merger.
// ----------------------------------------------------------------------------
module lcrc_tok_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcrc_pkg::tok_t tok_i,
  output logic           full_o,
  input  logic           pop_i,
  output lcrc_pkg::tok_t tok_o,
  output logic           valid_o
);

  lcrc_pkg::tok_t                    mem_q [lcrc_pkg::TokDepth];
  logic [lcrc_pkg::TokPtrBits-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [lcrc_pkg::TokCntBits-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == lcrc_pkg::TokCntBits'(lcrc_pkg::TokDepth));
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/lcrc_back.sv
// ----------------------------------------------------------------------------
// Line color run classifier back end
// Merges classified characters into runs and queues the finished results.
// ----------------------------------------------------------------------------
module lcrc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lcrc_pkg::tok_t tok_i,
  input  logic           tok_valid_i,
  output logic           tok_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lcrc_pkg::out_t out_o
);

  logic                            run_open_q, run_open_d;
  logic [lcrc_pkg::ColBits-1:0]    start_q, start_d;
  logic [lcrc_pkg::ColBits-1:0]    len_q, len_d;
  logic [lcrc_pkg::ColorBits-1:0]  color_q, color_d;
  logic [2:0]                      done_q, done_d;

  logic [2:0]                      rem, sel;
  logic [lcrc_pkg::ColBits-1:0]    pos;
  logic [lcrc_pkg::ColorBits-1:0]  color;
  logic [lcrc_pkg::ColBits:0]      run_end;
  logic                            is_fin, is_char, extend, emit, step;
  logic                            res_push, res_full, res_pop;
  lcrc_pkg::out_t                  res;

  lcrc_pkg::out_t                  mem_q [lcrc_pkg::ResDepth];
  logic [lcrc_pkg::ResPtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [lcrc_pkg::ResCntBits-1:0] cnt_q, cnt_d;

  always_comb begin
    rem = {tok_i.eol, tok_i.vis_b, tok_i.vis_a} & ~done_q;
    priority if (rem[0]) begin
      sel = 3'b001;
    end else if (rem[1]) begin
      sel = 3'b010;
    end else if (rem[2]) begin
      sel = 3'b100;
    end else begin
      sel = 3'b000;
    end
    is_fin  = sel[2];
    is_char = sel[0] || sel[1];
    pos     = sel[0] ? tok_i.pos_a : tok_i.pos_b;
    color   = sel[0] ? tok_i.color_a : tok_i.color_b;
    run_end = {1'b0, start_q} + {1'b0, len_q};
    extend  = run_open_q && (color == color_q) && ({1'b0, pos} == run_end) && (len_q != '1);
    emit    = is_fin || (is_char && run_open_q && !extend);
    step    = tok_valid_i && (sel != '0) && (!emit || !res_full);
    res_push  = step && emit;
    tok_pop_o = tok_valid_i && ((rem == '0) || (step && ((rem & ~sel) == '0)));

    res.run_present  = is_fin ? run_open_q : 1'b1;
    res.run_start    = run_open_q ? start_q : '0;
    res.run_length   = run_open_q ? len_q : '0;
    res.run_color    = run_open_q ? color_q : lcrc_pkg::ColorDefault;
    res.indent_width = tok_i.indent;
    res.line_done    = is_fin;

    run_open_d = run_open_q;
    start_d    = start_q;
    len_d      = len_q;
    color_d    = color_q;
    if (step) begin
      if (is_fin) begin
        run_open_d = 1'b0;
      end else if (extend) begin
        len_d = len_q + 1'b1;
      end else begin
        run_open_d = 1'b1;
        start_d    = pos;
        len_d      = lcrc_pkg::ColBits'(1);
        color_d    = color;
      end
    end

    if (tok_pop_o) begin
      done_d = '0;
    end else if (step) begin
      done_d = done_q | sel;
    end else begin
      done_d = done_q;
    end
  end

  assign res_full = (cnt_q == lcrc_pkg::ResCntBits'(lcrc_pkg::ResDepth));
  assign empty_o  = (cnt_q == '0);
  assign res_pop  = pop_i && !empty_o;
  assign out_o    = mem_q[rd_q];

  always_comb begin
    wr_d = res_push ? wr_q + 1'b1 : wr_q;
    rd_d = res_pop ? rd_q + 1'b1 : rd_q;
    unique case ({res_push, res_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      mem_q[wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      start_q    <= '0;
      len_q      <= '0;
      color_q    <= lcrc_pkg::ColorDefault;
      done_q     <= '0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      run_open_q <= run_open_d;
      start_q    <= start_d;
      len_q      <= len_d;
      color_q    <= color_d;
      done_q     <= done_d;
      wr_q       <= wr_d;
      rd_q       <= rd_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/line_color_run_classifier_top.sv
// ----------------------------------------------------------------------------
// Line color run classifier
// Splits line text into colored runs of adjacent same-class characters.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Beat
//  input     push_i / full_o      in_i: one character, end of line, no character
//  result    pop_i / empty_o      out_o: one run or line end marker
//  config    cfg_valid_i/ready_o  cfg_data_i: tab width in columns
//
//  The front end takes one character per cycle while full_o is low and classifies
//  it when the next character arrives; a line end classifies both in that cycle.
//  The run merger handles one classified character or line end per cycle while
//  the result queue has room, so a line end carrying two characters is split up.
//  Results leave one per cycle; full_o rises when the four-entry token queue
//  fills. After reset the tab width is four and the block is empty.
// ----------------------------------------------------------------------------
module line_color_run_classifier_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcrc_pkg::TabBits-1:0]  cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  lcrc_pkg::in_t                 in_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output lcrc_pkg::out_t                out_o
);

  logic           tok_push, tok_full, tok_pop, tok_valid;
  lcrc_pkg::tok_t tok_in, tok_out;

  assign cfg_ready_o = 1'b1;
  assign full_o      = tok_full;

  lcrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push_i),
    .in_i        (in_i),
    .tok_full_i  (tok_full),
    .tok_push_o  (tok_push),
    .tok_o       (tok_in)
  );

  lcrc_tok_fifo u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .tok_i   (tok_in),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .tok_o   (tok_out),
    .valid_o (tok_valid)
  );

  lcrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_out),
    .tok_valid_i (tok_valid),
    .tok_pop_o   (tok_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_o       (out_o)
  );

endmodule

// File: hw/rtl/lcrc_checker.sv
// ----------------------------------------------------------------------------
// Line color run classifier checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lcrc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty_o,
  input logic           pop_i,
  input lcrc_pkg::out_t out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_o)))
    else $error("Stalled result beat changed.");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_o.run_present) |->
      (out_o.line_done && (out_o.run_length == '0) && (out_o.run_start == '0) &&
       (out_o.run_color == lcrc_pkg::ColorDefault)))
    else $error("Line end marker carries run fields.");

  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_o.run_present) |->
      ((out_o.run_length != '0) && (out_o.run_color <= lcrc_pkg::ColorType)))
    else $error("Run beat is empty or has a bad color.");

  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_o.line_done) |-> out_o.run_present)
    else $error("Mid-line beat without a run.");

endmodule

bind line_color_run_classifier_top lcrc_checker u_lcrc_checker (.*);

// File: sim/line_color_run_classifier_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line color run classifier testbench
// Sends short lines of text with random content, bursts and gaps, and
// compares every run that leaves the block with a run predicted in the
// bench. A directed table comes first, then random lines under several tab
// widths, with long result stalls that make the input queue fill.
// ----------------------------------------------------------------------------
module line_color_run_classifier_top_tb;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ColMax       = (1 << lcrc_pkg::ColBits) - 1;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned StallLimit   = 2000;

  typedef struct {
    lcrc_pkg::in_t  beat;
    bit             typed;
    bit             typed_one;
    lcrc_pkg::out_t res;
  } stim_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [lcrc_pkg::TabBits-1:0] cfg_data_i  = '0;
  logic                         push_i      = 1'b0;
  logic                         full_o;
  lcrc_pkg::in_t                in_i        = '0;
  logic                         pop_i       = 1'b0;
  logic                         empty_o;
  lcrc_pkg::out_t               out_o;

  logic           beat_typed     = 1'b0;
  logic           beat_typed_one = 1'b0;
  lcrc_pkg::out_t beat_typed_res = '0;
  logic [3:0]     hold_req       = '0;

  lcrc_pkg::out_t pending_runs[$];
  stim_row_t      dir_rows[$];
  int unsigned mismatches  = 0;
  int unsigned line_beats  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;

  logic [lcrc_pkg::TabBits-1:0]   tab_width    = lcrc_pkg::TabColumnsReset;
  logic [lcrc_pkg::CharBits-1:0]  held_ch      = '0;
  bit                             held_ok      = 1'b0;
  bit                             indent_phase = 1'b1;
  int unsigned                    indent_cols  = 0;
  int unsigned                    body_col     = 0;
  bit                             str_flag     = 1'b0;
  bit                             cmt_flag     = 1'b0;
  bit                             run_live     = 1'b0;
  int unsigned                    run_first    = 0;
  int unsigned                    run_len      = 0;
  logic [lcrc_pkg::ColorBits-1:0] run_col      = lcrc_pkg::ColorDefault;

  line_color_run_classifier_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_i       (in_i),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_o      (out_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned col_add(int unsigned a, int unsigned b);
    return (a + b > ColMax) ? ColMax : a + b;
  endfunction

  function automatic lcrc_pkg::out_t run_res(bit present, int unsigned start,
                                             int unsigned len,
                                             logic [lcrc_pkg::ColorBits-1:0] color,
                                             int unsigned indent, bit done);
    lcrc_pkg::out_t r;
    r.run_present  = present;
    r.run_start    = start[lcrc_pkg::ColBits-1:0];
    r.run_length   = len[lcrc_pkg::ColBits-1:0];
    r.run_color    = color;
    r.indent_width = indent[lcrc_pkg::ColBits-1:0];
    r.line_done    = done;
    return r;
  endfunction

  function automatic void queue_run(lcrc_pkg::out_t r);
    pending_runs.insert(pending_runs.size(), r);
  endfunction

  task automatic take_char(logic [lcrc_pkg::CharBits-1:0] c, bit has_nx,
                           logic [lcrc_pkg::CharBits-1:0] nx);
    bit                             blank;
    int unsigned                    col;
    logic [lcrc_pkg::ColorBits-1:0] color;
    blank = (c == lcrc_pkg::ChSpace) || (c == lcrc_pkg::ChTab);
    if (indent_phase && blank) begin
      indent_cols = col_add(indent_cols, (c == lcrc_pkg::ChTab) ? int'(tab_width) : 1);
      return;
    end
    indent_phase = 1'b0;
    if (!str_flag && has_nx && c == lcrc_pkg::ChSlash && nx == lcrc_pkg::ChSlash) begin
      cmt_flag = 1'b1;
    end
    if (!cmt_flag && (c == lcrc_pkg::ChDquote || c == lcrc_pkg::ChSquote)) begin
      str_flag = !str_flag;
    end
    col = body_col;
    body_col = col_add(body_col, 1);
    if (blank) begin
      return;
    end
    color = lcrc_pkg::ColorDefault;
    if (cmt_flag) begin
      color = lcrc_pkg::ColorComment;
    end else if (str_flag) begin
      color = lcrc_pkg::ColorString;
    end else if (c >= lcrc_pkg::ChDigit0 && c <= lcrc_pkg::ChDigit9) begin
      color = lcrc_pkg::ColorNumber;
    end else if (c == lcrc_pkg::ChLparen || c == lcrc_pkg::ChRparen ||
                 c == lcrc_pkg::ChLbrace || c == lcrc_pkg::ChRbrace ||
                 c == lcrc_pkg::ChLbrack || c == lcrc_pkg::ChRbrack ||
                 c == lcrc_pkg::ChLess || c == lcrc_pkg::ChGreater) begin
      color = lcrc_pkg::ColorBracket;
    end else if (c >= lcrc_pkg::ChUpperA && c <= lcrc_pkg::ChUpperZ && has_nx &&
                 nx >= lcrc_pkg::ChLowerA && nx <= lcrc_pkg::ChLowerZ) begin
      color = lcrc_pkg::ColorType;
    end
    if (run_live && run_col == color && col == run_first + run_len && run_len < ColMax) begin
      run_len++;
      return;
    end
    if (run_live) begin
      queue_run(run_res(1'b1, run_first, run_len, run_col, indent_cols, 1'b0));
    end
    run_live  = 1'b1;
    run_first = col;
    run_len   = 1;
    run_col   = color;
  endtask

  task automatic end_line();
    if (run_live) begin
      queue_run(run_res(1'b1, run_first, run_len, run_col, indent_cols, 1'b1));
    end else begin
      queue_run(run_res(1'b0, 0, 0, lcrc_pkg::ColorDefault, indent_cols, 1'b1));
    end
    held_ch      = '0;
    held_ok      = 1'b0;
    indent_phase = 1'b1;
    indent_cols  = 0;
    body_col     = 0;
    str_flag     = 1'b0;
    cmt_flag     = 1'b0;
    run_live     = 1'b0;
    run_first    = 0;
    run_len      = 0;
    run_col      = lcrc_pkg::ColorDefault;
  endtask

  task automatic predict_runs(lcrc_pkg::in_t b);
    if (b.no_character) begin
      if (!b.end_of_line) begin
        return;
      end
      if (held_ok) begin
        take_char(held_ch, 1'b0, '0);
      end
      end_line();
      return;
    end
    if (held_ok) begin
      take_char(held_ch, 1'b1, b.character);
    end
    held_ch = b.character;
    held_ok = 1'b1;
    if (b.end_of_line) begin
      take_char(held_ch, 1'b0, '0);
      end_line();
    end
  endtask

  task automatic check_run(lcrc_pkg::out_t exp, lcrc_pkg::out_t got);
    if (got.run_present !== exp.run_present) begin
      $error("run_present: expected %0d, got %0d", exp.run_present, got.run_present);
      mismatches++;
    end
    if (got.run_start !== exp.run_start) begin
      $error("run_start: expected %0d, got %0d", exp.run_start, got.run_start);
      mismatches++;
    end
    if (got.run_length !== exp.run_length) begin
      $error("run_length: expected %0d, got %0d", exp.run_length, got.run_length);
      mismatches++;
    end
    if (got.run_color !== exp.run_color) begin
      $error("run_color: expected %0d, got %0d", exp.run_color, got.run_color);
      mismatches++;
    end
    if (got.indent_width !== exp.indent_width) begin
      $error("indent_width: expected %0d, got %0d", exp.indent_width, got.indent_width);
      mismatches++;
    end
    if (got.line_done !== exp.line_done) begin
      $error("line_done: expected %0d, got %0d", exp.line_done, got.line_done);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    int unsigned queued;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        tab_width = cfg_data_i;
      end
      if (push_i && !full_o) begin
        queued = pending_runs.size();
        predict_runs(in_i);
        if (beat_typed) begin
          while (pending_runs.size() > queued) begin
            void'(pending_runs.pop_back());
          end
          if (beat_typed_one) begin
            queue_run(beat_typed_res);
          end
        end
      end
      if (pop_i && !empty_o) begin
        if (pending_runs.size() == 0) begin
          $error("unexpected run beat: start %0d, length %0d", out_o.run_start,
                 out_o.run_length);
          mismatches++;
        end else begin
          check_run(pending_runs.pop_front(), out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == StallLimit) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [3:0]  hold_seen;
    int unsigned hold_left;
    int unsigned rx_phase;
    int unsigned rx_mode;
    logic [7:0]  rx_mask;
    if (!rst_ni) begin
      hold_seen = '0;
      hold_left = 0;
      rx_phase  = 0;
      rx_mode   = 0;
      rx_mask   = 8'hFF;
      pop_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
      pop_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop_i <= 1'b0;
    end else begin
      if (rx_phase % 32 == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mask = 8'($urandom_range(1, 255));
      end
      rx_phase++;
      case (rx_mode)
        0: pop_i <= 1'b1;
        1: pop_i <= ($urandom_range(0, 3) != 0);
        2: pop_i <= 1'($urandom_range(0, 1));
        default: pop_i <= rx_mask[rx_phase % 8];
      endcase
    end
  end

  function automatic stim_row_t row(logic [lcrc_pkg::CharBits-1:0] ch, bit eol, bit none);
    stim_row_t r;
    r.beat.character    = ch;
    r.beat.end_of_line  = eol;
    r.beat.no_character = none;
    r.typed     = 1'b0;
    r.typed_one = 1'b0;
    r.res       = '0;
    return r;
  endfunction

  function automatic stim_row_t fixed(logic [lcrc_pkg::CharBits-1:0] ch, bit eol, bit none,
                                      bit one, lcrc_pkg::out_t res);
    stim_row_t r;
    r           = row(ch, eol, none);
    r.typed     = 1'b1;
    r.typed_one = one;
    r.res       = res;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [lcrc_pkg::CharBits-1:0] any_char();
    return lcrc_pkg::CharBits'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(stim_row_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    push_i         <= 1'b1;
    in_i           <= r.beat;
    beat_typed     <= r.typed;
    beat_typed_one <= r.typed_one;
    beat_typed_res <= r.res;
    do @(posedge clk_i); while (full_o);
    burst_left--;
    if (!r.beat.no_character || r.beat.end_of_line) begin
      line_beats++;
    end
  endtask

  function automatic logic [lcrc_pkg::CharBits-1:0] pick_char();
    case ($urandom_range(0, 11))
      0: return lcrc_pkg::ChSpace;
      1: return lcrc_pkg::ChTab;
      2: return $urandom_range(0, 1) ? lcrc_pkg::ChDquote : lcrc_pkg::ChSquote;
      3: return lcrc_pkg::ChSlash;
      4: return lcrc_pkg::CharBits'($urandom_range(lcrc_pkg::ChDigit0, lcrc_pkg::ChDigit9));
      5: begin
        case ($urandom_range(0, 7))
          0: return lcrc_pkg::ChLparen;
          1: return lcrc_pkg::ChRparen;
          2: return lcrc_pkg::ChLbrace;
          3: return lcrc_pkg::ChRbrace;
          4: return lcrc_pkg::ChLbrack;
          5: return lcrc_pkg::ChRbrack;
          6: return lcrc_pkg::ChLess;
          default: return lcrc_pkg::ChGreater;
        endcase
      end
      6, 7: return lcrc_pkg::CharBits'($urandom_range(lcrc_pkg::ChUpperA, lcrc_pkg::ChUpperZ));
      8, 9: return lcrc_pkg::CharBits'($urandom_range(lcrc_pkg::ChLowerA, lcrc_pkg::ChLowerZ));
      default: return any_char();
    endcase
  endfunction

  task automatic send_line(int unsigned max_body);
    int unsigned n_ind;
    int unsigned n_body;
    bit          end_on_none;
    int unsigned i;
    n_ind       = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
    n_body      = $urandom_range(0, max_body);
    end_on_none = (n_ind + n_body == 0) || ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_ind; i++) begin
      send_beat(row($urandom_range(0, 1) ? lcrc_pkg::ChTab : lcrc_pkg::ChSpace,
                    !end_on_none && n_body == 0 && i == n_ind - 1, 1'b0));
    end
    for (i = 0; i < n_body; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_beat(row(any_char(), 1'b0, 1'b1));
      end
      send_beat(row(pick_char(), !end_on_none && i == n_body - 1, 1'b0));
    end
    if (end_on_none) begin
      send_beat(row(any_char(), 1'b1, 1'b1));
    end
  endtask

  task automatic send_lines(int unsigned beats);
    line_beats = 0;
    while (line_beats < beats) begin
      send_line(12);
    end
  endtask

  task automatic drain();
    push_i <= 1'b0;
    burst_left = 0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_tab_width(logic [lcrc_pkg::TabBits-1:0] w);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    add_row(fixed(8'hFF, 1'b0, 1'b1, 1'b0, '0));
    add_row(fixed(8'h00, 1'b1, 1'b1, 1'b1,
                  run_res(1'b0, 0, 0, lcrc_pkg::ColorDefault, 0, 1'b1)));
    add_row(fixed(lcrc_pkg::ChLowerZ, 1'b1, 1'b0, 1'b1,
                  run_res(1'b1, 0, 1, lcrc_pkg::ColorDefault, 0, 1'b1)));
    add_row(fixed(lcrc_pkg::ChDigit9, 1'b1, 1'b0, 1'b1,
                  run_res(1'b1, 0, 1, lcrc_pkg::ColorNumber, 0, 1'b1)));
    add_row(fixed(lcrc_pkg::ChRbrace, 1'b1, 1'b0, 1'b1,
                  run_res(1'b1, 0, 1, lcrc_pkg::ColorBracket, 0, 1'b1)));
    add_row(fixed(8'hFF, 1'b1, 1'b0, 1'b1,
                  run_res(1'b1, 0, 1, lcrc_pkg::ColorDefault, 0, 1'b1)));
    add_row(fixed(lcrc_pkg::ChTab, 1'b0, 1'b0, 1'b0, '0));
    add_row(fixed(lcrc_pkg::ChSpace, 1'b0, 1'b0, 1'b0, '0));
    add_row(fixed(8'h00, 1'b1, 1'b1, 1'b1,
                  run_res(1'b0, 0, 0, lcrc_pkg::ColorDefault, 5, 1'b1)));
    add_row(row(lcrc_pkg::ChSpace, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChUpperA, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChLowerA + 8'd1, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChLess, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChDigit0, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChSquote, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChLowerA, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChSquote, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChSlash, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChSlash, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChUpperZ, 1'b1, 1'b0));
    add_row(row(lcrc_pkg::ChUpperZ, 1'b0, 1'b0));
    add_row(row(8'h00, 1'b1, 1'b1));
    add_row(row(lcrc_pkg::ChDquote, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChSlash, 1'b0, 1'b0));
    add_row(row(lcrc_pkg::ChSlash, 1'b1, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k]);
    end
    drain();

    hold_req <= hold_req + 4'd1;
    send_lines(90);
    drain();

    write_tab_width(5'd0);
    send_lines(50);
    drain();

    write_tab_width(5'd31);
    send_lines(50);
    drain();

    write_tab_width(5'd1);
    send_lines(20);
    hold_req <= hold_req + 4'd1;
    send_lines(40);
    drain();

    write_tab_width(5'd16);
    send_lines(50);
    drain();

    write_tab_width(lcrc_pkg::TabBits'($urandom_range(0, 31)));
    send_lines(50);
    drain();

    if (mismatches == 0 && pending_runs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
